// ===== sv/byte_stuffing_framer_crc16_unit_defines.svh =====
// Assertion macros used by the checker file of the byte-stuffing framer.
// Depends on nothing; each file that uses the macros takes this header by include.
`ifndef BYTE_STUFFING_FRAMER_CRC16_UNIT_DEFINES_SVH
`define BYTE_STUFFING_FRAMER_CRC16_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("framer check failed");

// The consequent must hold in the cycle after the antecedent.
`define BSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("framer check failed");

`endif

// ===== sv/bsf_pkg.sv =====
// Shared types, constants and the CRC step function of the byte-stuffing framer.
// Depends on nothing; every framer module imports it.
package bsf_pkg;

    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [15:0] CRC_TOP     = 16'h8000;
    localparam logic [7:0]  STUFF_XOR   = 8'h20;
    localparam logic [7:0]  FLAG_RESET  = 8'd126;
    localparam logic [7:0]  ESC_RESET   = 8'd125;
    localparam int          QUEUE_DEPTH_DEF = 2;

    localparam int          CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_FLAG   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ESCAPE = 1'd1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_end;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic        open;
        logic [15:0] crc;
    } cmd_t;

    function automatic logic [15:0] crc16_update(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if ((c & CRC_TOP) != 16'h0000)
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== sv/byte_stuffing_framer_crc16_unit.sv =====
// Byte-stuffing framer with CRC-16: the front end, command queue and back-end sequencer.
// An accepted item is written into the command queue, and its first word then into the output register.
// Throughput: one output word per cycle while the output is not stalled; an item yields
// one to eight words, set by the back-end sequencer that fills the single output register.
// Reset clears frame state, CRC, queue and output valid, and loads flag 126 and escape 125.
module byte_stuffing_framer_crc16_unit
    import bsf_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_item_t               in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_item_t              out_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data
);

    logic q_full;
    logic q_push;
    cmd_t q_cmd;
    logic q_pop;
    logic q_head_valid;
    cmd_t q_head_cmd;

    bsf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    bsf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd)
    );

    bsf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

// ===== sv/bsf_front.sv =====
// Front end of the framer: accepts input words, keeps the running CRC and frame state.
// Depends on bsf_pkg; pushes one command per accepted word into the queue.
module bsf_front
    import bsf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_data,
    input  logic     q_full,
    output logic     q_push,
    output cmd_t     q_cmd
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic        in_frame_reg;
    logic        in_frame_next;
    logic [15:0] crc_upd;

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;
    assign crc_upd  = crc16_update(crc_reg, in_data.data_byte);

    always_comb
    begin
        q_cmd.data = in_data.data_byte;
        q_cmd.last = in_data.last_byte;
        q_cmd.open = !in_frame_reg;
        q_cmd.crc  = crc_upd;
    end

    always_comb
    begin
        crc_next      = crc_reg;
        in_frame_next = in_frame_reg;
        if (q_push)
        begin
            crc_next      = in_data.last_byte ? 16'h0000 : crc_upd;
            in_frame_next = !in_data.last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg      <= 16'h0000;
            in_frame_reg <= 1'b0;
        end
        else
        begin
            crc_reg      <= crc_next;
            in_frame_reg <= in_frame_next;
        end
    end

endmodule

// ===== sv/bsf_queue.sv =====
// Short command queue between the front end and the back-end sequencer.
// Depends on bsf_pkg for the command type.
module bsf_queue
    import bsf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/bsf_back.sv =====
// Back end of the framer: the configuration registers and a sequencer that turns each queued command
// into stuffed data words, with an opening flag for a frame's first word and stuffed CRC and closing flag for its last.
// Depends on bsf_pkg; drives the registered output channel.
module bsf_back
    import bsf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data,
    input  logic                   head_valid,
    input  cmd_t                   head_cmd,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_item_t              out_data
);

    localparam logic [3:0] PH_IDLE  = 4'd0;
    localparam logic [3:0] PH_OPEN  = 4'd1;
    localparam logic [3:0] PH_DATA  = 4'd2;
    localparam logic [3:0] PH_DATA2 = 4'd3;
    localparam logic [3:0] PH_CRCL  = 4'd4;
    localparam logic [3:0] PH_CRCL2 = 4'd5;
    localparam logic [3:0] PH_CRCH  = 4'd6;
    localparam logic [3:0] PH_CRCH2 = 4'd7;
    localparam logic [3:0] PH_CLOSE = 4'd8;

    logic [7:0] flag_reg;
    logic [7:0] esc_reg;
    logic [3:0] phase_reg;
    logic [3:0] phase_next;
    logic [3:0] cur_phase;
    logic       out_valid_reg;
    logic       out_valid_next;
    out_item_t  out_item_reg;
    out_item_t  out_item_next;
    out_item_t  item;
    logic [7:0] src;
    logic       needs_esc;
    logic       load;
    logic       fire;
    logic       done;
    logic [3:0] step_phase;

    assign load      = !out_valid_reg || !out_stall;
    assign fire      = head_valid && load;
    assign cur_phase = (phase_reg == PH_IDLE) ? (head_cmd.open ? PH_OPEN : PH_DATA) : phase_reg;

    always_comb
    begin
        src        = head_cmd.data;
        needs_esc  = 1'b0;
        item       = '0;
        done       = 1'b0;
        step_phase = PH_IDLE;
        case (cur_phase)
            PH_OPEN:
            begin
                item.out_byte = flag_reg;
                step_phase    = PH_DATA;
            end
            PH_DATA, PH_CRCL, PH_CRCH:
            begin
                if (cur_phase == PH_CRCL)
                begin
                    src = head_cmd.crc[7:0];
                end
                else if (cur_phase == PH_CRCH)
                begin
                    src = head_cmd.crc[15:8];
                end
                needs_esc = (src == flag_reg) || (src == esc_reg);
                if (needs_esc)
                begin
                    item.out_byte = esc_reg;
                    step_phase    = cur_phase + 4'd1;
                end
                else
                begin
                    item.out_byte = src;
                    step_phase    = cur_phase + 4'd2;
                end
            end
            PH_DATA2, PH_CRCL2, PH_CRCH2:
            begin
                if (cur_phase == PH_CRCL2)
                begin
                    src = head_cmd.crc[7:0];
                end
                else if (cur_phase == PH_CRCH2)
                begin
                    src = head_cmd.crc[15:8];
                end
                item.out_byte = src ^ STUFF_XOR;
                step_phase    = cur_phase + 4'd1;
            end
            PH_CLOSE:
            begin
                item.out_byte  = flag_reg;
                item.frame_end = 1'b1;
                step_phase     = PH_IDLE;
            end
            default:
            begin
                step_phase = PH_IDLE;
            end
        endcase
        if (step_phase == PH_CRCL && !head_cmd.last)
        begin
            step_phase = PH_IDLE;
        end
        done          = (step_phase == PH_IDLE);
        item.run_last = done;
    end

    assign pop = fire && done;

    always_comb
    begin
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (fire)
        begin
            phase_next     = step_phase;
            out_valid_next = 1'b1;
            out_item_next  = item;
        end
        else if (load)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg      <= FLAG_RESET;
            esc_reg       <= ESC_RESET;
            phase_reg     <= PH_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_FLAG)
            begin
                flag_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == REG_ESCAPE)
            begin
                esc_reg <= cfg_data;
            end
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

endmodule

// ===== sv/bsf_checker.sv =====
// Port-level checks for the byte-stuffing framer, bound to the top level.
// Depends on bsf_pkg and the assertion macros in the defines header.
`include "byte_stuffing_framer_crc16_unit_defines.svh"

module bsf_checker
    import bsf_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_data
);

    // A stalled output word stays valid and unchanged.
    `BSF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
    // The closing flag always ends the run of words for its input.
    `BSF_ASSERT_NOW(a_close_is_last, clk, rst_n, out_valid && out_data.frame_end, out_data.run_last)
    // Within one input's run, the next word follows with no gap.
    `BSF_ASSERT_NEXT(a_run_no_gap, clk, rst_n, out_valid && !out_stall && !out_data.run_last, out_valid)

endmodule

bind byte_stuffing_framer_crc16_unit bsf_checker u_bsf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
